// File: rtl/iee_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Infix evaluator package
// Shared widths, character codes, operation codes and control structs.
// ----------------------------------------------------------------------------
package iee_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int CountWidth  = $clog2(VALUE_WIDTH);

   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharStar  = 8'h2A;
   localparam logic [7:0] CharSlash = 8'h2F;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef logic [VALUE_WIDTH-1:0] word_type;

   typedef struct packed {
      logic start;
      logic divide;
   } unit_ctl_type;

endpackage : iee_pkg
`default_nettype wire

// File: rtl/iee_req_intf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one expression character per item.
// ----------------------------------------------------------------------------
interface iee_req_intf;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface : iee_req_intf
`default_nettype wire

// File: rtl/iee_rsp_intf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one evaluated expression per item.
// ----------------------------------------------------------------------------
interface iee_rsp_intf;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic [1:0]         last_operation;
   logic               leads_with_digit;
   logic               divide_by_zero;

   modport source (output valid, output value, output last_operation,
                   output leads_with_digit, output divide_by_zero, input ready);
   modport sink   (input valid, input value, input last_operation,
                   input leads_with_digit, input divide_by_zero, output ready);
endinterface : iee_rsp_intf
`default_nettype wire

// File: rtl/iee_muldiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative multiply / divide unit
// One bit per cycle around a single shared adder: shift-add multiply (low
// word kept) or restoring signed divide truncating toward zero.
// ----------------------------------------------------------------------------
module iee_muldiv (
   input  logic                  clock,
   input  logic                  reset,
   input  iee_pkg::unit_ctl_type ctl,
   input  iee_pkg::word_type     operand_a,
   input  iee_pkg::word_type     operand_b,
   output logic                  done,
   output iee_pkg::word_type     result
);
   import iee_pkg::*;

   localparam int W = VALUE_WIDTH;

   // work_a: product or remainder; work_b: multiplicand or quotient;
   // work_c: multiplier or divisor
   word_type              work_a_ff, work_a_in;
   word_type              work_b_ff, work_b_in;
   word_type              work_c_ff, work_c_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  divide_ff, divide_in;
   logic                  negate_ff, negate_in;

   logic [W:0] add_x;
   logic [W:0] add_y;
   logic [W:0] add_sum;
   word_type   mag_a;
   word_type   mag_b;

   assign mag_a = operand_a[W-1] ? ('0 - operand_a) : operand_a;
   assign mag_b = operand_b[W-1] ? ('0 - operand_b) : operand_b;

   // shared adder: accumulate for multiply, trial subtract for divide
   assign add_x   = divide_ff ? {work_a_ff, work_b_ff[W-1]} : {1'b0, work_a_ff};
   assign add_y   = divide_ff ? {1'b0, work_c_ff} : {1'b0, work_b_ff};
   assign add_sum = add_x + (add_y ^ {(W+1){divide_ff}}) + (W+1)'(divide_ff);

   always_comb begin
      work_a_in = work_a_ff;
      work_b_in = work_b_ff;
      work_c_in = work_c_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      divide_in = divide_ff;
      negate_in = negate_ff;
      if (ctl.start) begin
         busy_in   = 1'b1;
         divide_in = ctl.divide;
         count_in  = CountWidth'(W - 1);
         work_a_in = '0;
         if (ctl.divide) begin
            work_b_in = mag_a;
            work_c_in = mag_b;
            negate_in = operand_a[W-1] ^ operand_b[W-1];
         end else begin
            work_b_in = operand_a;
            work_c_in = operand_b;
            negate_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (divide_ff) begin
            if (!add_sum[W]) begin
               work_a_in = add_sum[W-1:0];
               work_b_in = {work_b_ff[W-2:0], 1'b1};
            end else begin
               work_a_in = add_x[W-1:0];
               work_b_in = {work_b_ff[W-2:0], 1'b0};
            end
         end else begin
            if (work_c_ff[0]) begin
               work_a_in = add_sum[W-1:0];
            end
            work_b_in = {work_b_ff[W-2:0], 1'b0};
            work_c_in = {1'b0, work_c_ff[W-1:1]};
         end
         count_in = count_ff - CountWidth'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         divide_ff <= 1'b0;
         negate_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         busy_ff   <= busy_in;
         done_ff   <= done_in;
         divide_ff <= divide_in;
         negate_ff <= negate_in;
         count_ff  <= count_in;
      end
      work_a_ff <= work_a_in;
      work_b_ff <= work_b_in;
      work_c_ff <= work_c_in;
   end

   assign done   = done_ff;
   assign result = divide_ff ? (negate_ff ? ('0 - work_b_ff) : work_b_ff) : work_a_ff;

endmodule : iee_muldiv
`default_nettype wire

// File: rtl/infix_expression_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none
// Digits and other characters are taken in S_IDLE; an operator or the final
// character then passes through S_CLOSE, and a waiting * or / goes on to
// S_WAIT for the shared multiply/divide unit, which retires one bit per cycle;
// a zero divisor skips the unit.
// The final character then loads the result register in S_FINISH, which
// waits, and takes no new character, while an earlier result is not yet taken.
// Synchronous active-high reset clears the evaluator; no clearing pass.
// ----------------------------------------------------------------------------
// Infix expression evaluator
// Character-serial evaluator for + - * / with precedence, no stack.
// ----------------------------------------------------------------------------
module infix_expression_evaluator (
   input  logic        clock,
   input  logic        reset,
   iee_req_intf.sink   req_chan,
   iee_rsp_intf.source rsp_chan
);
   import iee_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_CLOSE  = 4'b0010,
      S_WAIT   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   word_type  acc_ff, acc_in;
   word_type  term_ff, term_in;
   word_type  sum_ff, sum_in;
   op_type    pending_ff, pending_in;
   op_type    applied_ff, applied_in;
   op_type    next_op_ff, next_op_in;
   logic      has_op_ff, has_op_in;
   logic      last_ff, last_in;
   logic      first_ff, first_in;
   logic      lead_ff, lead_in;
   logic      zdiv_ff, zdiv_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   op_type             rsp_op_ff, rsp_op_in;
   logic               rsp_lead_ff, rsp_lead_in;
   logic               rsp_zdiv_ff, rsp_zdiv_in;

   logic         is_digit;
   logic         is_op;
   op_type       char_op;
   word_type     total;
   unit_ctl_type unit_ctl;
   logic         unit_done;
   word_type     unit_result;

   iee_muldiv u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .ctl       (unit_ctl),
      .operand_a (term_ff),
      .operand_b (acc_ff),
      .done      (unit_done),
      .result    (unit_result)
   );

   assign is_digit = (req_chan.char_code >= CharZero) && (req_chan.char_code <= CharNine);
   assign total    = sum_ff + term_ff;

   always_comb begin
      is_op   = 1'b1;
      char_op = OP_ADD;
      unique case (req_chan.char_code)
         CharPlus:  char_op = OP_ADD;
         CharMinus: char_op = OP_SUB;
         CharStar:  char_op = OP_MUL;
         CharSlash: char_op = OP_DIV;
         default:   is_op = 1'b0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      pending_in   = pending_ff;
      applied_in   = applied_ff;
      next_op_in   = next_op_ff;
      has_op_in    = has_op_ff;
      last_in      = last_ff;
      first_in     = first_ff;
      lead_in      = lead_ff;
      zdiv_in      = zdiv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_op_in    = rsp_op_ff;
      rsp_lead_in  = rsp_lead_ff;
      rsp_zdiv_in  = rsp_zdiv_ff;
      unit_ctl     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               if (first_ff) begin
                  lead_in  = is_digit;
                  first_in = 1'b0;
               end
               if (is_digit) begin
                  acc_in = (acc_ff << 3) + (acc_ff << 1)
                         + VALUE_WIDTH'(req_chan.char_code - CharZero);
               end
               has_op_in  = is_op;
               next_op_in = char_op;
               last_in    = req_chan.end_of_text;
               if (is_op || req_chan.end_of_text) begin
                  state_in = S_CLOSE;
               end
            end
         end
         S_CLOSE: begin
            // apply the waiting sign to the number just closed
            acc_in = '0;
            if (has_op_ff) begin
               pending_in = next_op_ff;
            end
            applied_in = pending_ff;
            state_in   = last_ff ? S_FINISH : S_IDLE;
            unique case (pending_ff)
               OP_ADD: begin
                  sum_in  = total;
                  term_in = acc_ff;
               end
               OP_SUB: begin
                  sum_in  = total;
                  term_in = '0 - acc_ff;
               end
               OP_MUL: begin
                  unit_ctl.start = 1'b1;
                  state_in       = S_WAIT;
               end
               OP_DIV: begin
                  if (acc_ff == '0) begin
                     zdiv_in = 1'b1;
                     term_in = '0;
                  end else begin
                     unit_ctl.start  = 1'b1;
                     unit_ctl.divide = 1'b1;
                     state_in        = S_WAIT;
                  end
               end
               default: ;
            endcase
         end
         S_WAIT: begin
            if (unit_done) begin
               term_in  = unit_result;
               state_in = last_ff ? S_FINISH : S_IDLE;
            end
         end
         S_FINISH: begin
            // hold until the result register is free, then clear for next item
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = zdiv_ff ? '0 : 32'(signed'(total));
               rsp_op_in    = applied_ff;
               rsp_lead_in  = lead_ff;
               rsp_zdiv_in  = zdiv_ff;
               acc_in       = '0;
               term_in      = '0;
               sum_in       = '0;
               pending_in   = OP_ADD;
               applied_in   = OP_ADD;
               first_in     = 1'b1;
               lead_in      = 1'b0;
               zdiv_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         term_ff      <= '0;
         sum_ff       <= '0;
         pending_ff   <= OP_ADD;
         applied_ff   <= OP_ADD;
         next_op_ff   <= OP_ADD;
         has_op_ff    <= 1'b0;
         last_ff      <= 1'b0;
         first_ff     <= 1'b1;
         lead_ff      <= 1'b0;
         zdiv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         term_ff      <= term_in;
         sum_ff       <= sum_in;
         pending_ff   <= pending_in;
         applied_ff   <= applied_in;
         next_op_ff   <= next_op_in;
         has_op_ff    <= has_op_in;
         last_ff      <= last_in;
         first_ff     <= first_in;
         lead_ff      <= lead_in;
         zdiv_ff      <= zdiv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_op_ff    <= rsp_op_in;
      rsp_lead_ff  <= rsp_lead_in;
      rsp_zdiv_ff  <= rsp_zdiv_in;
   end

   assign req_chan.ready            = (state_ff == S_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.value            = rsp_value_ff;
   assign rsp_chan.last_operation   = rsp_op_ff;
   assign rsp_chan.leads_with_digit = rsp_lead_ff;
   assign rsp_chan.divide_by_zero   = rsp_zdiv_ff;

endmodule : infix_expression_evaluator
`default_nettype wire

// File: rtl/iee_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Evaluator port checker
// Watches the request and response ports of the evaluator over time.
// ----------------------------------------------------------------------------
module iee_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_end_of_text,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_value,
   input logic        rsp_divide_by_zero
);

   // a pending result stays up until taken
   ap_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response item dropped before it was taken");

   ap_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_value))
      else $error("stalled response value changed");

   ap_zdiv_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_value == 32'd0)
      else $error("divide by zero result carries nonzero value");

   // the final character always closes a number, so the next cycle is busy
   ap_final_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end_of_text |=> !req_ready)
      else $error("ready right after final character");

endmodule : iee_checker

bind infix_expression_evaluator iee_checker u_iee_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_end_of_text    (req_chan.end_of_text),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_value          (rsp_chan.value),
   .rsp_divide_by_zero (rsp_chan.divide_by_zero)
);
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix expression evaluator testbench
// Feeds expression text one character per item through the request channel,
// predicts each evaluated result with a precedence evaluator of its own and
// compares every result item field by field, in order, as it leaves the block.
// Directed expressions cover the corner cases; random well-formed expressions
// and character noise follow, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
   import iee_pkg::*;

   typedef struct {
      word_type value;
      op_type   last_op;
      logic     lead_digit;
      logic     zero_div;
   } expr_result_type;

   // Precedence evaluator and store of expected results
   class expr_scoreboard;
      word_type        number_acc;
      word_type        term;
      word_type        sum_done;
      op_type          sign_waiting;
      op_type          op_applied;
      bit              first_pending;
      bit              lead_digit;
      bit              zero_div;
      expr_result_type results_due[$];
      int unsigned     errors;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         number_acc    = '0;
         term          = '0;
         sum_done      = '0;
         sign_waiting  = OP_ADD;
         op_applied    = OP_ADD;
         first_pending = 1'b1;
         lead_digit    = 1'b0;
         zero_div      = 1'b0;
      endfunction

      // Signed division truncating toward zero, done on magnitudes
      function word_type div_trunc(word_type a, word_type b);
         word_type ma, mb, q;
         ma = a[VALUE_WIDTH-1] ? -a : a;
         mb = b[VALUE_WIDTH-1] ? -b : b;
         q  = ma / mb;
         return (a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1]) ? -q : q;
      endfunction

      function void close_number();
         case (sign_waiting)
            OP_ADD: begin
               sum_done   = sum_done + term;
               term       = number_acc;
               op_applied = OP_ADD;
            end
            OP_SUB: begin
               sum_done   = sum_done + term;
               term       = -number_acc;
               op_applied = OP_SUB;
            end
            OP_MUL: begin
               term       = term * number_acc;
               op_applied = OP_MUL;
            end
            default: begin
               if (number_acc == '0) begin
                  zero_div = 1'b1;
                  term     = '0;
               end else begin
                  term = div_trunc(term, number_acc);
               end
               op_applied = OP_DIV;
            end
         endcase
         number_acc = '0;
      endfunction

      function void note_char(logic [7:0] c, logic eot);
         bit              is_digit;
         bit              is_op;
         op_type          op;
         expr_result_type r;
         is_digit = (c >= CharZero) && (c <= CharNine);
         is_op    = 1'b1;
         op       = OP_ADD;
         case (c)
            CharPlus:  op = OP_ADD;
            CharMinus: op = OP_SUB;
            CharStar:  op = OP_MUL;
            CharSlash: op = OP_DIV;
            default:   is_op = 1'b0;
         endcase
         if (first_pending) begin
            lead_digit    = is_digit;
            first_pending = 1'b0;
         end
         if (is_digit) number_acc = number_acc * 10 + word_type'(c - CharZero);
         if (eot || is_op) begin
            close_number();
            if (is_op) sign_waiting = op;
         end
         if (eot) begin
            r.value      = zero_div ? word_type'(0) : sum_done + term;
            r.last_op    = op_applied;
            r.lead_digit = lead_digit;
            r.zero_div   = zero_div;
            results_due.push_back(r);
            clear();
         end
      endfunction

      function void check_result(logic [31:0] value, logic [1:0] last_op,
                                 logic lead, logic dz);
         expr_result_type r;
         if (results_due.size() == 0) begin
            $display("%0t: result item with none expected: value %0d", $time,
                     $signed(value));
            errors++;
            return;
         end
         r = results_due.pop_front();
         if (value !== r.value) begin
            $display("%0t: value expected %0d actual %0d", $time,
                     $signed(r.value), $signed(value));
            errors++;
         end
         if (last_op !== r.last_op) begin
            $display("%0t: last_operation expected %0d actual %0d", $time,
                     r.last_op, last_op);
            errors++;
         end
         if (lead !== r.lead_digit) begin
            $display("%0t: leads_with_digit expected %0d actual %0d", $time,
                     r.lead_digit, lead);
            errors++;
         end
         if (dz !== r.zero_div) begin
            $display("%0t: divide_by_zero expected %0d actual %0d", $time,
                     r.zero_div, dz);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;
   int unsigned chars_sent = 0;
   expr_scoreboard scoreboard;

   iee_req_intf req_if();
   iee_rsp_intf rsp_if();

   infix_expression_evaluator uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_if.ready <= reset ? 1'b0 : (quiet || $urandom_range(99) >= 14);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         scoreboard.check_result(rsp_if.value, rsp_if.last_operation,
                                 rsp_if.leads_with_digit, rsp_if.divide_by_zero);
   end

   task automatic push_char(logic [7:0] c, logic eot);
      while (!quiet && $urandom_range(99) < 14) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.char_code   <= c;
      req_if.end_of_text <= eot;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      scoreboard.note_char(c, eot);
      chars_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] pick_op();
      case ($urandom_range(3))
         0:       return CharPlus;
         1:       return CharMinus;
         2:       return CharStar;
         default: return CharSlash;
      endcase
   endfunction

   task automatic send_chars(logic [7:0] text[$]);
      for (int i = 0; i < text.size(); i++) push_char(text[i], i == text.size() - 1);
   endtask

   // Well-formed expression with random numbers, operators and a little noise
   task automatic send_random_expression();
      logic [7:0] text[$];
      int         terms;
      int         digits;
      terms = $urandom_range(1, 6);
      if ($urandom_range(99) < 5) text.push_back(pick_op());
      for (int t = 0; t < terms; t++) begin
         if (t > 0) text.push_back(pick_op());
         digits = ($urandom_range(99) < 10) ? $urandom_range(4, 12) : $urandom_range(1, 3);
         for (int d = 0; d < digits; d++) begin
            text.push_back(CharZero + 8'($urandom_range(9)));
            if ($urandom_range(99) < 3) text.push_back(8'($urandom_range(255)));
         end
      end
      case ($urandom_range(9))
         0:       text.push_back(pick_op());
         1:       text.push_back(8'($urandom_range(255)));
         default: ;
      endcase
      send_chars(text);
   endtask

   // Noise: arbitrary characters, biased toward digits and operators
   task automatic send_random_noise();
      logic [7:0] text[$];
      int         len;
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(2))
            0:       text.push_back(CharZero + 8'($urandom_range(9)));
            1:       text.push_back(pick_op());
            default: text.push_back(8'($urandom_range(255)));
         endcase
      end
      send_chars(text);
   endtask

   initial begin
      int wait_cycles;
      req_if.valid       = 1'b0;
      req_if.char_code   = '0;
      req_if.end_of_text = 1'b0;
      scoreboard = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corner cases
      send_text("*5");
      send_text("3+");
      send_text("8/0");
      send_text("9-7/2 ");
      send_text("2147483648/4294967295");
      send_text("99999999999*65536x");
      send_text("7");
      push_char(8'hFF, 1'b1);
      push_char(8'h00, 1'b0);
      push_char(8'h39, 1'b1);

      while (chars_sent < 1200) begin
         quiet = (chars_sent >= 500) && (chars_sent < 800);
         if ($urandom_range(99) < 85) send_random_expression();
         else send_random_noise();
      end
      quiet = 1'b0;
      req_if.valid <= 1'b0;

      wait_cycles = 0;
      while (scoreboard.results_due.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (80) @(posedge clock);
      if (scoreboard.results_due.size() != 0) begin
         $display("%0t: %0d expected result items never arrived", $time,
                  scoreboard.results_due.size());
         scoreboard.errors++;
      end
      if (scoreboard.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule : tb
